/* sv/fpdf_pkg.sv */
// Package for the fixed-point decimal formatter: widths, character codes,
// microcode step codes, control word type and the control store.
// No dependencies.
`timescale 1ns / 1ps

package fpdf_pkg;

  localparam int VAL_W = 25;               // input and magnitude width
  localparam int DIG_W = 4;                // one BCD digit
  localparam int DEF_INT_DIGITS = 5;

  // divide by ten: q = (x * DIV_MUL) >> DIV_SHIFT, low by at most one
  localparam int DIV_SHIFT = 28;
  localparam logic [VAL_W-1:0] DIV_MUL = 25'd26843545;
  localparam logic [DIG_W-1:0] TEN = 4'd10;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // datapath operations
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_ABS  = 3'd1;  // sign, magnitude, saturation
  localparam logic [2:0] OP_MUL  = 3'd2;  // start divide by ten
  localparam logic [2:0] OP_DFR0 = 3'd3;  // hundredths digit
  localparam logic [2:0] OP_DFR1 = 3'd4;  // tenths digit
  localparam logic [2:0] OP_DINT = 3'd5;  // push integer digit
  localparam logic [2:0] OP_POP  = 3'd6;  // pop integer digit

  // character selection
  localparam logic [2:0] EM_NONE = 3'd0;
  localparam logic [2:0] EM_SIGN = 3'd1;  // only when negative and non-zero
  localparam logic [2:0] EM_INT  = 3'd2;
  localparam logic [2:0] EM_DOT  = 3'd3;
  localparam logic [2:0] EM_F1   = 3'd4;
  localparam logic [2:0] EM_F2   = 3'd5;

  // sequencing
  localparam logic [1:0] J_NEXT = 2'd0;
  localparam logic [1:0] J_LOOP = 2'd1;   // to target while the loop test holds
  localparam logic [1:0] J_END  = 2'd2;

  // step codes
  localparam logic [3:0] S_ABS  = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_D1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_D2   = 4'd4;
  localparam logic [3:0] S_SIGN = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_D3   = 4'd7;
  localparam logic [3:0] S_INT  = 4'd8;
  localparam logic [3:0] S_DOT  = 4'd9;
  localparam logic [3:0] S_F1   = 4'd10;
  localparam logic [3:0] S_F2   = 4'd11;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] emit;
    logic [1:0] jmp;
    logic [3:0] target;
  } uop_t;

  function automatic uop_t ucode_rom(input logic [3:0] step);
    uop_t w;
    w = '{op: OP_NOP, emit: EM_NONE, jmp: J_END, target: S_ABS};
    unique case (step)
      S_ABS:  w = '{op: OP_ABS,  emit: EM_NONE, jmp: J_NEXT, target: S_ABS};
      S_M1:   w = '{op: OP_MUL,  emit: EM_NONE, jmp: J_NEXT, target: S_ABS};
      S_D1:   w = '{op: OP_DFR0, emit: EM_NONE, jmp: J_NEXT, target: S_ABS};
      S_M2:   w = '{op: OP_MUL,  emit: EM_NONE, jmp: J_NEXT, target: S_ABS};
      S_D2:   w = '{op: OP_DFR1, emit: EM_NONE, jmp: J_NEXT, target: S_ABS};
      S_SIGN: w = '{op: OP_NOP,  emit: EM_SIGN, jmp: J_NEXT, target: S_ABS};
      S_M3:   w = '{op: OP_MUL,  emit: EM_NONE, jmp: J_NEXT, target: S_ABS};
      S_D3:   w = '{op: OP_DINT, emit: EM_NONE, jmp: J_LOOP, target: S_M3};
      S_INT:  w = '{op: OP_POP,  emit: EM_INT,  jmp: J_LOOP, target: S_INT};
      S_DOT:  w = '{op: OP_NOP,  emit: EM_DOT,  jmp: J_NEXT, target: S_ABS};
      S_F1:   w = '{op: OP_NOP,  emit: EM_F1,   jmp: J_NEXT, target: S_ABS};
      S_F2:   w = '{op: OP_NOP,  emit: EM_F2,   jmp: J_END,  target: S_ABS};
      default: w = '{op: OP_NOP, emit: EM_NONE, jmp: J_END,  target: S_ABS};
    endcase
    return w;
  endfunction

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

/* sv/fixed_point_decimal_formatter.sv */
// Top level of the fixed-point decimal formatter: microcoded sequencer,
// digit stack and character output. Depends on fpdf_pkg and fpdf_div10.
`timescale 1ns / 1ps

// Usage
//   A request is taken on a rising edge with start high and busy low;
//   in_value_hundredths is the signed value times 100. The text follows as
//   one character per out_valid pulse on out_char_code, out_last set on the
//   final one: optional '-', integer digits, '.', two fraction digits.
//   Each pulse lasts exactly one cycle; the receiver cannot stall it.
//   Busy stays high from the accepting edge to the last character step, and
//   no new request is taken while it is high. A '-' is on the ports once
//   both fraction digits are divided out, the first digit once every
//   integer digit is. Each digit costs two steps of the shared divide-by-ten
//   unit plus one output step; the fraction digits take four. The last
//   character is on the ports in the first cycle with busy low; the edge
//   that ends that cycle can take a new request.
//   Magnitudes beyond INT_DIGITS integer digits saturate to all nines.
//   Reset (synchronous, rst_n low) returns the sequencer to idle and drops
//   out_valid; no other state is kept between numbers.
module fixed_point_decimal_formatter
  import fpdf_pkg::*;
#(
  parameter int INT_DIGITS = DEF_INT_DIGITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] in_value_hundredths,
  output logic                    out_valid,
  output logic [7:0]              out_char_code,
  output logic                    out_last
);

  localparam int ND_W  = $clog2(INT_DIGITS + 1);
  localparam int IDX_W = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;
  localparam logic [63:0] LIMIT = pow10(INT_DIGITS) * 64'd100 - 64'd1;
  localparam logic [ND_W:0] DIG_MAX = INT_DIGITS[ND_W:0];

  logic                    busy_r, busy_nxt;
  logic [3:0]              pc_r, pc_nxt;
  logic signed [VAL_W-1:0] in_r;
  logic [VAL_W-1:0]        x_r;
  logic                    neg_r, nz_r;
  logic [DIG_W-1:0]        frac0_r, frac1_r;
  logic [DIG_W-1:0]        dig_r [INT_DIGITS];
  logic [ND_W-1:0]         nd_r;
  logic [ND_W-1:0]         rd_idx;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  uop_t             uop;
  logic [VAL_W-1:0] mag, mag_sat;
  logic [VAL_W-1:0] q;
  logic [DIG_W-1:0] r;
  logic             loop_ok;
  logic             accept;

  assign accept = start && !busy_r;
  assign uop    = ucode_rom(pc_r);
  assign rd_idx = nd_r - 1'b1;

  fpdf_div10 u_div10 (
    .clk  (clk),
    .load (busy_r && uop.op == OP_MUL),
    .x_i  (x_r),
    .q_o  (q),
    .r_o  (r)
  );

  always_comb begin
    mag     = in_r[VAL_W-1] ? (~in_r + 1'b1) : in_r;
    mag_sat = ({(64 - VAL_W)'(0), mag} > LIMIT) ? LIMIT[VAL_W-1:0] : mag;
  end

  // loop tests for the digit push and pop steps
  always_comb begin
    unique case (uop.op)
      OP_DINT: loop_ok = (q != '0) && (({1'b0, nd_r} + 1'b1) < DIG_MAX);
      OP_POP:  loop_ok = nd_r != ND_W'(1);
      default: loop_ok = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = S_ABS;
    end else if (busy_r) begin
      unique case (uop.jmp)
        J_NEXT:  pc_nxt = pc_r + 1'b1;
        J_LOOP:  pc_nxt = loop_ok ? uop.target : pc_r + 1'b1;
        J_END:   busy_nxt = 1'b0;
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_char_nxt  = CH_ZERO;
    out_last_nxt  = 1'b0;
    if (busy_r) begin
      unique case (uop.emit)
        EM_NONE: out_valid_nxt = 1'b0;
        EM_SIGN: begin
          out_valid_nxt = neg_r && nz_r;
          out_char_nxt  = CH_MINUS;
        end
        EM_INT: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO + 8'(dig_r[rd_idx[IDX_W-1:0]]);
        end
        EM_DOT: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_DOT;
        end
        EM_F1: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO + 8'(frac1_r);
        end
        EM_F2: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO + 8'(frac0_r);
          out_last_nxt  = 1'b1;
        end
        default: out_valid_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= S_ABS;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    if (accept) begin
      in_r <= in_value_hundredths;
    end
    if (busy_r) begin
      unique case (uop.op)
        OP_ABS: begin
          x_r   <= mag_sat;
          neg_r <= in_r[VAL_W-1];
          nz_r  <= mag_sat != '0;
          nd_r  <= '0;
        end
        OP_DFR0: begin
          x_r     <= q;
          frac0_r <= r;
        end
        OP_DFR1: begin
          x_r     <= q;
          frac1_r <= r;
        end
        OP_DINT: begin
          x_r                    <= q;
          dig_r[nd_r[IDX_W-1:0]] <= r;
          nd_r                   <= nd_r + 1'b1;
        end
        OP_POP:  nd_r <= rd_idx;
        OP_MUL, OP_NOP: ;
        default: ;
      endcase
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

`ifndef SYNTH
  a_last_is_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last flag without a character");

  a_valid_from_work : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("character emitted while idle");

  a_last_ends_request : assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> !$past(busy_nxt))
    else $error("final character while sequence still running");

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && pc_r == S_ABS))
    else $error("request not started");

  a_stack_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (busy && pc_r == S_INT) |-> (nd_r != '0 && {1'b0, nd_r} <= DIG_MAX))
    else $error("digit stack out of range");
`endif

endmodule

/* sv/fpdf_div10.sv */
// Two-step divide by ten: registered reciprocal product, then one correction.
// Depends on fpdf_pkg.
`timescale 1ns / 1ps

module fpdf_div10
  import fpdf_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic [VAL_W-1:0] x_i,
  output logic [VAL_W-1:0] q_o,
  output logic [DIG_W-1:0] r_o
);

  localparam int PROD_W = 2 * VAL_W;

  logic [VAL_W-1:0]  x_r;
  logic [PROD_W-1:0] prod_r;
  logic [VAL_W-1:0]  q_est;
  logic [VAL_W-1:0]  q10;
  logic [VAL_W-1:0]  rem;
  logic              rem_big;

  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= x_i;
      prod_r <= PROD_W'(x_i) * PROD_W'(DIV_MUL);
    end
  end

  always_comb begin
    q_est   = VAL_W'(prod_r[PROD_W-1:DIV_SHIFT]);
    q10     = (q_est << 3) + (q_est << 1);
    rem     = x_r - q10;                 // below twenty
    rem_big = rem >= VAL_W'(TEN);
    q_o     = q_est + VAL_W'(rem_big);
    r_o     = rem_big ? (rem[DIG_W-1:0] - TEN) : rem[DIG_W-1:0];
  end

endmodule

/* tb/fixed_point_decimal_formatter_tb.sv */
// Testbench for fixed_point_decimal_formatter: directed table, then random numbers
// under several sender idle patterns, each char checked against typed or predicted text.
// Depends on fpdf_pkg and the formatter RTL.
`timescale 1ns / 1ps

module fixed_point_decimal_formatter_tb;
  import fpdf_pkg::*;

  localparam int FMT_DIGITS = DEF_INT_DIGITS;
  localparam int RANDOM_PER_PHASE = 59;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  typedef struct {
    int    value;
    string text;     // empty: predicted
  } number_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [VAL_W-1:0] in_value_hundredths = '0;
  logic                    out_valid;
  logic [7:0]              out_char_code;
  logic                    out_last;

  text_char_t expected_text[$];
  int         error_count = 0;
  int         chars_checked = 0;
  int         numbers_sent = 0;
  int         cycle_count = 0;

  // hand-typed where the text is obvious; the rest go through the predictor
  number_row_t number_table[] = '{
    '{0,         "0.00"},
    '{1,         "0.01"},
    '{-1,        "-0.01"},
    '{-5,        "-0.05"},
    '{99,        "0.99"},
    '{-99,       "-0.99"},
    '{100,       "1.00"},
    '{-100,      "-1.00"},
    '{10,        "0.10"},
    '{9999999,   "99999.99"},
    '{-9999999,  "-99999.99"},
    '{10000000,  "99999.99"},
    '{-10000000, "-99999.99"},
    '{16777215,  "99999.99"},
    '{-16777216, "-99999.99"},
    '{1000000,   "10000.00"},
    '{12345,     ""},
    '{-12345,    ""},
    '{-1234567,  ""},
    '{4200,      ""},
    '{-70,       ""},
    '{505,       ""},
    '{-99900,    ""},
    '{31415,     ""},
    '{-8000001,  ""}
  };

  fixed_point_decimal_formatter #(
    .INT_DIGITS(FMT_DIGITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value_hundredths(in_value_hundredths),
    .out_valid          (out_valid),
    .out_char_code      (out_char_code),
    .out_last           (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void push_char(input logic [7:0] code, input logic last);
    expected_text.push_back('{code: code, last: last});
  endfunction

  // sign, saturated integer digits, dot, two fraction digits of the magnitude
  function automatic void predict_text(input logic signed [VAL_W-1:0] v);
    logic             neg;
    logic [VAL_W-1:0] mag_bits;
    longint unsigned  mag;
    longint unsigned  ceiling;
    longint unsigned  int_part;
    longint unsigned  frac;
    logic [7:0]       digits[$];
    neg = v[VAL_W-1];
    mag_bits = neg ? -v : v;
    mag = mag_bits;
    ceiling = 1;
    for (int i = 0; i < FMT_DIGITS; i++) ceiling = ceiling * 10;
    ceiling = ceiling * 100 - 1;
    if (mag > ceiling) mag = ceiling;
    int_part = mag / 100;
    frac = mag % 100;
    if (neg && mag != 0) push_char(CH_MINUS, 1'b0);
    if (int_part == 0) begin
      push_char(CH_ZERO, 1'b0);
    end else begin
      while (int_part > 0) begin
        digits.push_front(CH_ZERO + 8'(int_part % 10));
        int_part = int_part / 10;
      end
      foreach (digits[i]) push_char(digits[i], 1'b0);
    end
    push_char(CH_DOT, 1'b0);
    push_char(CH_ZERO + 8'(frac / 10), 1'b0);
    push_char(CH_ZERO + 8'(frac % 10), 1'b1);
  endfunction

  // mostly in-range values spread over every digit count; some raw 25-bit patterns
  function automatic logic signed [VAL_W-1:0] random_value();
    logic signed [VAL_W-1:0] v;
    longint unsigned         lo;
    longint unsigned         hi;
    int                      nd;
    if ($urandom_range(99) < 10) begin
      v = VAL_W'($urandom);
    end else begin
      nd = $urandom_range(FMT_DIGITS);
      lo = 0;
      hi = 99;
      for (int i = 0; i < nd; i++) begin
        lo = hi + 1;
        hi = hi * 10 + 9;
      end
      v = VAL_W'(lo + $urandom_range(int'(hi - lo)));
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  // one request; expectation recorded at the accepting edge
  task automatic send_number(input logic signed [VAL_W-1:0] v, input string typed,
                             input int idle_pct);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value_hundredths <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed.len() == 0) begin
      predict_text(v);
    end else begin
      for (int i = 0; i < typed.len(); i++) push_char(typed[i], i == typed.len() - 1);
    end
    numbers_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected char, expected none, got 0x%02h last=%0b",
                 $time, out_char_code, out_last);
        error_count++;
      end else begin
        want = expected_text.pop_front();
        chars_checked++;
        if (out_char_code !== want.code) begin
          $display("%0t: char_code mismatch, expected 0x%02h, got 0x%02h",
                   $time, want.code, out_char_code);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int idle_phases[4];
    idle_phases = '{0, 48, 28, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (number_table[i])
      send_number(VAL_W'(number_table[i].value), number_table[i].text, 0);

    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_number(random_value(), "", idle_phases[p]);
      // hold the sender off until the formatter has emptied out
      if (p == 1) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Formatted %0d numbers (%0d from the table), %0d characters checked",
             numbers_sent, number_table.size(), chars_checked);
    $display("Covered zero, sign below one, saturation, all digit counts, idle and back-to-back");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
